[hdl/sme_pkg.sv]
`default_nettype none
package sme_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VAL_W       = 16;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int OUT_DEPTH_W = 5;
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int DIV_CNT_W   = $clog2(VAL_W + 1);
  localparam int VAL_LIMIT   = 30000;

  localparam logic [FUNC_W-1:0] FN_LOAD   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SUB    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MUL    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DIV    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DUP    = 3'd5;
  localparam logic [FUNC_W-1:0] FN_FINISH = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZ     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DEPTH    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd6;

  localparam logic signed [PROD_W-1:0] RES_MAX = PROD_W'(VAL_LIMIT);
  localparam logic signed [PROD_W-1:0] RES_MIN = -RES_MAX;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] top_value;
    logic [OUT_DEPTH_W-1:0]  depth;
  } out_item_t;

endpackage
`default_nettype wire

[hdl/sme_if.sv]
`default_nettype none
interface sme_in_if;
  logic               valid;
  logic               ready;
  sme_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sme_out_if;
  logic               valid;
  logic               ready;
  sme_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/sme_cell.sv]
`default_nettype none
module sme_cell (
  input  wire                                 clk,
  input  wire sme_pkg::cell_cmd_t             cmd,
  input  wire logic signed [sme_pkg::VAL_W-1:0] ext_val,
  input  wire logic signed [sme_pkg::VAL_W-1:0] prev_val,
  input  wire logic signed [sme_pkg::VAL_W-1:0] next_val,
  output logic signed [sme_pkg::VAL_W-1:0]      val
);

  logic signed [sme_pkg::VAL_W-1:0] val_r;
  logic signed [sme_pkg::VAL_W-1:0] val_nxt;

  always_comb begin
    unique case (cmd)
      sme_pkg::CELL_HOLD:      val_nxt = val_r;
      sme_pkg::CELL_LOAD:      val_nxt = ext_val;
      sme_pkg::CELL_FROM_PREV: val_nxt = prev_val;
      sme_pkg::CELL_FROM_NEXT: val_nxt = next_val;
      default:                 val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
`default_nettype wire

[hdl/sme_div.sv]
`default_nettype none
module sme_div (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  wire logic signed [sme_pkg::VAL_W-1:0] dividend,
  input  wire logic signed [sme_pkg::VAL_W-1:0] divisor,
  output logic                                  done,
  output logic signed [sme_pkg::VAL_W:0]        quotient
);

  localparam int W = sme_pkg::VAL_W;

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [sme_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W:0]                  rem_r, rem_nxt;
  logic [W-1:0]                q_r, q_nxt;
  logic [W-1:0]                d_r, d_nxt;
  logic                        neg_r, neg_nxt;
  logic [W:0]                  trial;

  assign trial = {rem_r[W-1:0], q_r[W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      // work on magnitudes, fix the sign at the end
      q_nxt    = dividend[W-1] ? (~dividend + 1'b1) : dividend;
      d_nxt    = divisor[W-1] ? (~divisor + 1'b1) : divisor;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sme_pkg::DIV_CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule
`default_nettype wire

[hdl/stack_machine_executor.sv]
`default_nettype none
// Stack-machine execution unit. One item (func, operand) is taken at a time and
// gives exactly one result item with the sticky status, the top of stack (zero
// when empty) and the depth. The stack is a row of value cells that shift
// toward the top on a pop and away from it on a push. Each accepted item goes
// from the idle state through an execute state to a commit state that writes
// the output register once it is free; a div with enough operands, a non-zero
// divisor and no error set passes through a divide state between the two, held
// by the radix-2 divider that retires one quotient bit a cycle over 16 bits. A
// new item is taken once the previous one has been written to the output
// register, which may still be waiting on out_ch.ready.
module stack_machine_executor (
  input  wire       clk,
  input  wire       rst_n,
  sme_in_if.sink    in_ch,
  sme_out_if.source out_ch
);

  localparam int W  = sme_pkg::VAL_W;
  localparam int N  = sme_pkg::STACK_DEPTH;
  localparam int DW = sme_pkg::DEPTH_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic [sme_pkg::FUNC_W-1:0]          func_r, func_nxt;
  logic signed [W-1:0]                 opnd_r, opnd_nxt;
  logic signed [sme_pkg::PROD_W-1:0]   res_r, res_nxt;
  logic [DW-1:0]                       depth_r, depth_nxt;
  logic [sme_pkg::STATUS_W-1:0]        sticky_r, sticky_nxt;
  logic                                out_valid_r, out_valid_nxt;
  sme_pkg::out_item_t                  out_data_r, out_data_nxt;

  logic signed [W-1:0]                 cell_val [N];
  sme_pkg::cell_cmd_t                  cmd_top, cmd_rest;
  logic signed [W-1:0]                 top_ext;

  logic signed [W-1:0]                 b_val, a_val;
  logic signed [sme_pkg::PROD_W-1:0]   prod;
  logic                                is_arith, commit_go, div_start, div_done;
  logic signed [W:0]                   div_q;
  logic signed [W-1:0]                 new_top;

  assign b_val = cell_val[0];
  assign a_val = cell_val[1];
  assign prod  = a_val * b_val;

  assign is_arith  = (func_r == sme_pkg::FN_ADD) || (func_r == sme_pkg::FN_SUB) ||
                     (func_r == sme_pkg::FN_MUL) || (func_r == sme_pkg::FN_DIV);
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || out_ch.ready);
  assign div_start = (state_r == S_EXEC) && (func_r == sme_pkg::FN_DIV) &&
                     (sticky_r == sme_pkg::ST_OK) && (depth_r >= DW'(2)) &&
                     (b_val != '0);

  sme_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (a_val),
    .divisor  (b_val),
    .done     (div_done),
    .quotient (div_q)
  );

  // cell 0 is the top of stack
  sme_cell u_cell_top (
    .clk      (clk),
    .cmd      (cmd_top),
    .ext_val  (top_ext),
    .prev_val (cell_val[0]),
    .next_val (cell_val[1]),
    .val      (cell_val[0])
  );

  for (genvar i = 1; i < N; i++) begin : g_cell
    sme_cell u_cell (
      .clk      (clk),
      .cmd      (cmd_rest),
      .ext_val  (cell_val[i]),
      .prev_val (cell_val[i-1]),
      .next_val (cell_val[(i == N - 1) ? i : i + 1]),
      .val      (cell_val[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    opnd_nxt      = opnd_r;
    res_nxt       = res_r;
    depth_nxt     = depth_r;
    sticky_nxt    = sticky_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd_top       = sme_pkg::CELL_HOLD;
    cmd_rest      = sme_pkg::CELL_HOLD;
    top_ext       = res_r[W-1:0];
    new_top       = (depth_r == '0) ? '0 : cell_val[0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt  = in_ch.data.func;
          opnd_nxt  = in_ch.data.operand;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (func_r)
          sme_pkg::FN_ADD: res_nxt = sme_pkg::PROD_W'(a_val) + sme_pkg::PROD_W'(b_val);
          sme_pkg::FN_SUB: res_nxt = sme_pkg::PROD_W'(a_val) - sme_pkg::PROD_W'(b_val);
          default:         res_nxt = prod;
        endcase
        state_nxt = div_start ? S_DIV : S_COMMIT;
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = sme_pkg::PROD_W'(div_q);
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit_go) begin
          priority if (func_r == sme_pkg::FN_LOAD) begin
            cmd_top    = sme_pkg::CELL_LOAD;
            top_ext    = opnd_r;
            depth_nxt  = DW'(1);
            sticky_nxt = sme_pkg::ST_OK;
            new_top    = opnd_r;
          end else if (sticky_r != sme_pkg::ST_OK) begin
            // error sticks: stack frozen until the next load
          end else if (is_arith) begin
            priority if (depth_r < DW'(2)) begin
              sticky_nxt = sme_pkg::ST_UNDER;
            end else if (func_r == sme_pkg::FN_DIV && b_val == '0) begin
              sticky_nxt = sme_pkg::ST_DIVZ;
            end else if (res_r > sme_pkg::RES_MAX || res_r < sme_pkg::RES_MIN) begin
              sticky_nxt = sme_pkg::ST_RANGE;
            end else begin
              cmd_top   = sme_pkg::CELL_LOAD;
              cmd_rest  = sme_pkg::CELL_FROM_NEXT;
              depth_nxt = depth_r - 1'b1;
              new_top   = res_r[W-1:0];
            end
          end else if (func_r == sme_pkg::FN_DUP) begin
            priority if (depth_r == '0) begin
              sticky_nxt = sme_pkg::ST_UNDER;
            end else if (depth_r >= DW'(N)) begin
              sticky_nxt = sme_pkg::ST_FULL;
            end else begin
              cmd_rest  = sme_pkg::CELL_FROM_PREV;
              depth_nxt = depth_r + 1'b1;
            end
          end else if (func_r == sme_pkg::FN_FINISH) begin
            priority if (depth_r != DW'(1)) begin
              sticky_nxt = sme_pkg::ST_DEPTH;
            end else if (cell_val[0] != opnd_r) begin
              sticky_nxt = sme_pkg::ST_MISMATCH;
            end else begin
            end
          end else begin
            // unused code: report only
          end
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = sticky_nxt;
          out_data_nxt.top_value = new_top;
          out_data_nxt.depth     = sme_pkg::OUT_DEPTH_W'(depth_nxt);
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      sticky_r    <= sme_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r     <= func_nxt;
    opnd_r     <= opnd_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(N))
    else $error("stack depth beyond capacity");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_error_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_go && sticky_r != sme_pkg::ST_OK && func_r != sme_pkg::FN_LOAD)
      |=> $stable(depth_r) && $stable(sticky_r))
    else $error("stack or status moved while an error was set");

  a_commit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go |=> out_valid_r && state_r == S_IDLE)
    else $error("committed item not presented");

endmodule
`default_nettype wire
